@@ src/hap_pkg.sv @@
// hap_pkg: shared types, constants and codes for the haptic actuator pattern scheduler
// no dependencies
package hap_pkg;

   localparam int ActuatorCountDefault = 4;
   localparam int ActuatorCountMax = 8;

   localparam logic [15:0] KeepaliveReset = 16'd2000;
   localparam logic [7:0] OnTimeReset = 8'd10;
   localparam logic [7:0] TypesReset = 8'h00;
   localparam logic [15:0] CountsReset = 16'h8888;
   localparam logic [15:0] BeatPattern = 16'h00FF;

   localparam logic [2:0] KIND_TICK = 3'd0;
   localparam logic [2:0] KIND_PING = 3'd1;
   localparam logic [2:0] KIND_MODE = 3'd2;
   localparam logic [2:0] KIND_LEVEL = 3'd3;
   localparam logic [2:0] KIND_PARAM = 3'd4;

   localparam logic [2:0] MODE_OFF = 3'd0;
   localparam logic [2:0] MODE_TEMP = 3'd1;
   localparam logic [2:0] MODE_SERVO = 3'd2;
   localparam logic [2:0] MODE_VIB = 3'd3;
   localparam logic [2:0] MODE_BEAT = 3'd4;
   localparam logic [2:0] MODE_ROT = 3'd5;
   localparam logic [2:0] MODE_ELEC = 3'd6;

   localparam logic [2:0] ACT_OFF = 3'd0;
   localparam logic [2:0] ACT_TEMP = 3'd1;
   localparam logic [2:0] ACT_SERVO = 3'd2;
   localparam logic [2:0] ACT_VIB = 3'd3;
   localparam logic [2:0] ACT_DISC = 3'd4;
   localparam logic [2:0] ACT_ELEC = 3'd5;

   localparam logic [1:0] TYPE_VIB = 2'd0;
   localparam logic [1:0] TYPE_TEMP = 2'd1;
   localparam logic [1:0] TYPE_PRES = 2'd2;
   localparam logic [1:0] TYPE_ELEC = 2'd3;

   localparam logic [1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_ONTIME = 2'd1;
   localparam logic [1:0] CSR_TYPES = 2'd2;
   localparam logic [1:0] CSR_COUNTS = 2'd3;

   typedef struct packed {
      logic [1:0] target;
      logic [2:0] action;
      logic [15:0] level;
      logic [15:0] pattern;
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // accept input word
      logic tick_start;  // tick: bump counters, disconnect check
      logic sel_load;    // load current actuator into work regs
      logic mod_start;   // start remainder unit
      logic eval;        // evaluate actuator, may queue commands
      logic pop;         // pop one command into output stage
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic mod_busy;
      logic queue_empty;
      logic scan_last;
   } sts_type;

endpackage

@@ src/hap_rem.sv @@
// hap_rem: 32 by 17 bit restoring remainder unit, one quotient bit per cycle
// depends on nothing
module hap_rem (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        busy,
   output logic [16:0] remainder
);
   logic [31:0] num_ff, num_in;
   logic [17:0] acc_ff, acc_in;
   logic [16:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [17:0] shifted;

   always_comb begin
      num_in = num_ff;
      acc_in = acc_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {acc_ff[16:0], num_ff[31]};
      if (start) begin
         num_in = dividend;
         acc_in = '0;
         div_in = divisor;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[30:0], 1'b0};
         acc_in = (shifted >= {1'b0, div_ff}) ? shifted - {1'b0, div_ff} : shifted;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      acc_ff <= acc_in;
      div_ff <= div_in;
   end

   assign busy = busy_ff;
   assign remainder = acc_ff[16:0];
endmodule

@@ src/hap_ctrl.sv @@
// hap_ctrl: sequencer for tick scans and command drain
// depends on hap_pkg
module hap_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [2:0]        req_kind,
   input  logic              out_free,
   input  hap_pkg::sts_type  sts,
   output logic              req_ready,
   output hap_pkg::ctl_type  ctl
);
   import hap_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MOD  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EVAL = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_ready = (state_ff == ST_IDLE) && sts.queue_empty;
      ctl.take = req_fire;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_kind == KIND_TICK) begin
               ctl.tick_start = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.sel_load = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            ctl.mod_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!sts.mod_busy) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ctl.eval = 1'b1;
            state_in = sts.scan_last ? ST_DRAIN : ST_LOAD;
         end
         ST_DRAIN: begin
            if (sts.queue_empty) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ctl.pop = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_eval_after_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> !sts.mod_busy)
      else $error("eval while remainder busy");
   a_pop_drain: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> state_ff == ST_DRAIN && !sts.queue_empty)
      else $error("pop outside drain");
`endif
endmodule

@@ src/hap_dp.sv @@
// hap_dp: actuator state, counters, command queue and output stage
// depends on hap_pkg and hap_rem
module hap_dp #(
   parameter int ACTUATOR_COUNT = hap_pkg::ActuatorCountDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  hap_pkg::ctl_type  ctl,
   input  logic [2:0]        req_kind,
   input  logic [1:0]        req_index,
   input  logic [15:0]       req_value,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output hap_pkg::cmd_type  rsp_cmd,
   output logic              rsp_last,
   output logic              out_free,
   output hap_pkg::sts_type  sts
);
   import hap_pkg::*;

   localparam int AW = (ACTUATOR_COUNT > 1) ? $clog2(ACTUATOR_COUNT) : 1;
   localparam int QMAX = 2 * ACTUATOR_COUNT + 1;
   localparam int QD = 2 ** $clog2(QMAX);
   localparam int QW = $clog2(QD);
   localparam int QNW = QW + 1;

   function automatic logic [2:0] wrap_pos(logic [3:0] v, logic [3:0] c);
      logic [3:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (r >= c) r = r - c;
      end
      return r[2:0];
   endfunction

   logic [15:0] timeout_ff;
   logic [7:0]  ontime_ff;
   logic [7:0]  types_ff;
   logic [15:0] counts_ff;
   logic [31:0] tick_ff, tick_in;
   logic [15:0] keep_ff, keep_in;
   logic        link_ff, link_in;
   logic [2:0]  mode_ff [ACTUATOR_COUNT];
   logic        pend_ff [ACTUATOR_COUNT];
   logic [15:0] lvl_ff [ACTUATOR_COUNT];
   logic [15:0] set_ff [ACTUATOR_COUNT];
   logic [2:0]  pos_ff [ACTUATOR_COUNT];
   logic [AW-1:0] sel_ff, sel_in;

   logic [2:0]  w_mode;
   logic        w_pend;
   logic [15:0] w_lvl, w_set;
   logic [2:0]  w_pos;
   logic [1:0]  w_type;
   logic [3:0]  w_cnt;
   logic [16:0] divisor;
   logic        mod_busy;
   logic [16:0] rem;

   cmd_type     q_ff [QD];
   logic [QW-1:0]  qwr_ff, qrd_ff;
   logic [QNW-1:0] qn_ff;
   cmd_type     ev_a, ev_b;
   logic        ev_a_v, ev_b_v, ev_clr, ev_pos_wr;
   logic [2:0]  ev_pos;
   logic        disc_v;
   logic [1:0]  n_push;
   logic [QW-1:0] n_wr;

   cmd_type     out_ff;
   logic        outv_ff, outl_ff;

   assign sts.mod_busy = mod_busy;
   assign sts.queue_empty = (qn_ff == '0);
   assign sts.scan_last = (32'(sel_ff) == ACTUATOR_COUNT - 1);

   // per actuator view of the config registers
   always_comb begin
      w_type = TYPE_VIB;
      w_cnt = 4'd1;
      if (32'(sel_ff) < 4) begin
         w_type = types_ff[2*sel_ff[1:0] +: 2];
         w_cnt = counts_ff[4*sel_ff[1:0] +: 4];
      end
      if (w_cnt == 4'd0) w_cnt = 4'd1;
      if (w_cnt > 4'd8) w_cnt = 4'd8;
   end

   assign divisor = (w_mode == MODE_BEAT) ? 17'(ontime_ff) + 17'(w_set) : 17'(w_set);

   hap_rem u_rem (
      .clock(clock), .reset(reset), .start(ctl.mod_start), .dividend(tick_ff),
      .divisor(divisor), .busy(mod_busy), .remainder(rem)
   );

   // evaluation of the loaded actuator
   always_comb begin
      ev_a = '0; ev_b = '0; ev_a_v = 1'b0; ev_b_v = 1'b0; ev_clr = 1'b0;
      ev_pos_wr = 1'b0; ev_pos = '0;
      ev_a.target = 2'(sel_ff); ev_b.target = 2'(sel_ff);
      case (w_mode)
         MODE_OFF: begin
            ev_a.action = ACT_OFF; ev_a_v = w_pend;
         end
         MODE_TEMP: begin
            ev_a.action = ACT_TEMP; ev_a.level = w_lvl;
            ev_a_v = w_pend && w_type == TYPE_TEMP;
         end
         MODE_SERVO: begin
            ev_a.action = ACT_SERVO; ev_a.level = w_lvl;
            ev_a_v = w_pend && w_type == TYPE_PRES;
         end
         MODE_VIB: begin
            ev_a.action = ACT_VIB; ev_a.level = w_lvl; ev_a.pattern = w_set;
            ev_a_v = w_pend && w_type == TYPE_VIB;
         end
         MODE_BEAT: begin
            ev_a.action = ACT_VIB; ev_b.action = ACT_VIB;
            ev_a_v = w_pend && w_type == TYPE_VIB;
            if (w_type == TYPE_VIB && divisor != 17'd0) begin
               if (rem == 17'd0) begin
                  ev_b_v = 1'b1; ev_b.level = w_lvl; ev_b.pattern = BeatPattern;
               end else if (rem == 17'(ontime_ff)) begin
                  ev_b_v = 1'b1;
               end
            end
         end
         MODE_ROT: begin
            ev_a.action = ACT_VIB; ev_b.action = ACT_VIB;
            ev_a_v = w_pend && w_type == TYPE_VIB;
            if (w_type == TYPE_VIB && w_set != 16'd0 && rem == 17'd0) begin
               ev_pos = wrap_pos({1'b0, w_pos} + 4'd1, w_cnt);
               ev_pos_wr = 1'b1;
               ev_b_v = 1'b1; ev_b.level = w_lvl;
               ev_b.pattern = 16'd1 << ev_pos;
            end
         end
         MODE_ELEC: begin
            ev_a.action = ACT_ELEC; ev_a.level = w_lvl;
            ev_a_v = w_pend && w_type == TYPE_ELEC;
         end
         default: ;
      endcase
      ev_clr = ev_a_v;
   end

   always_comb begin
      tick_in = tick_ff; keep_in = keep_ff; link_in = link_ff; disc_v = 1'b0;
      sel_in = sel_ff;
      if (ctl.take && req_kind == KIND_PING) begin
         link_in = 1'b1; keep_in = timeout_ff;
      end
      if (ctl.tick_start) begin
         tick_in = tick_ff + 32'd1;
         sel_in = '0;
         if (link_ff) begin
            keep_in = keep_ff - 16'd1;
            if (keep_ff == 16'd1) begin
               link_in = 1'b0; disc_v = 1'b1;
            end
         end
      end
      if (ctl.eval && !sts.scan_last) sel_in = sel_ff + AW'(1);
      n_push = 2'(disc_v) + 2'(ctl.eval && ev_a_v) + 2'(ctl.eval && ev_b_v);
      n_wr = (ctl.eval && ev_a_v) ? qwr_ff + QW'(1) : qwr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= KeepaliveReset;
         ontime_ff <= OnTimeReset;
         types_ff <= TypesReset;
         counts_ff <= CountsReset;
         tick_ff <= '0;
         keep_ff <= KeepaliveReset;
         link_ff <= 1'b0;
         sel_ff <= '0;
         qwr_ff <= '0; qrd_ff <= '0; qn_ff <= '0;
         outv_ff <= 1'b0;
         for (int i = 0; i < ACTUATOR_COUNT; i++) begin
            mode_ff[i] <= MODE_OFF; pend_ff[i] <= 1'b0; lvl_ff[i] <= '0;
            set_ff[i] <= '0; pos_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_ONTIME: ontime_ff <= csr_wdata[7:0];
               CSR_TYPES: types_ff <= csr_wdata[7:0];
               CSR_COUNTS: counts_ff <= csr_wdata;
               default: ;
            endcase
         end
         tick_ff <= tick_in; keep_ff <= keep_in; link_ff <= link_in; sel_ff <= sel_in;
         if (ctl.take && 32'(req_index) < ACTUATOR_COUNT &&
             (req_kind == KIND_MODE || req_kind == KIND_LEVEL || req_kind == KIND_PARAM)) begin
            pend_ff[AW'(req_index)] <= 1'b1;
            if (req_kind == KIND_MODE && req_value <= 16'(MODE_ELEC))
               mode_ff[AW'(req_index)] <= req_value[2:0];
            if (req_kind == KIND_LEVEL) lvl_ff[AW'(req_index)] <= req_value;
            if (req_kind == KIND_PARAM) set_ff[AW'(req_index)] <= req_value;
         end
         if (ctl.eval) begin
            if (ev_clr) pend_ff[sel_ff] <= 1'b0;
            if (ev_pos_wr) pos_ff[sel_ff] <= ev_pos;
         end
         qwr_ff <= qwr_ff + QW'(n_push);
         if (ctl.pop) qrd_ff <= qrd_ff + QW'(1);
         qn_ff <= qn_ff + QNW'(n_push) - QNW'(ctl.pop);
         if (ctl.pop) begin
            outv_ff <= 1'b1;
         end else if (rsp_tready) begin
            outv_ff <= 1'b0;
         end
      end
      if (ctl.sel_load) begin
         w_mode <= mode_ff[sel_ff]; w_pend <= pend_ff[sel_ff]; w_lvl <= lvl_ff[sel_ff];
         w_set <= set_ff[sel_ff]; w_pos <= pos_ff[sel_ff];
      end
      if (disc_v) q_ff[qwr_ff] <= '{target: 2'd0, action: ACT_DISC, level: 16'd0, pattern: 16'd0};
      if (ctl.eval && ev_a_v) q_ff[qwr_ff] <= ev_a;
      if (ctl.eval && ev_b_v) q_ff[n_wr] <= ev_b;
      if (ctl.pop) begin
         out_ff <= q_ff[qrd_ff];
         outl_ff <= (qn_ff == QNW'(1));
      end
   end

   assign out_free = !outv_ff || rsp_tready;
   assign rsp_tvalid = outv_ff;
   assign rsp_cmd = out_ff;
   assign rsp_last = outl_ff;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qn_ff <= QNW'(QMAX))
      else $error("command queue overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> qn_ff != '0)
      else $error("pop of empty queue");
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      ctl.tick_start |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("tick count not advanced");
`endif
endmodule

@@ src/haptic_actuator_pattern_scheduler.sv @@
// Sequence: a ping or set word is taken while idle; a tick steps each actuator through load,
// remainder start, remainder wait and evaluation, then drains queued commands and returns to idle.
// Throughput: one word at a time; the next word is taken once the command queue is empty.
// Reset: synchronous active-high reset restores the config, counters, queue pointers and actuator state.
// haptic_actuator_pattern_scheduler: top level, depends on hap_pkg, hap_ctrl, hap_dp
module haptic_actuator_pattern_scheduler #(
   parameter int ACTUATOR_COUNT = hap_pkg::ActuatorCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // kind[2:0], actuator_index[4:3], value[20:5]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // target_actuator[1:0], action[4:2], drive_level[20:5],
                                    // channel_pattern[36:21]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import hap_pkg::*;

   ctl_type ctl;
   sts_type sts;
   cmd_type cmd;
   logic    out_free;
   logic    req_fire;

   assign req_fire = req_tvalid && req_tready;

   hap_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .req_kind(req_tdata[2:0]),
      .out_free(out_free), .sts(sts), .req_ready(req_tready), .ctl(ctl)
   );

   hap_dp #(.ACTUATOR_COUNT(ACTUATOR_COUNT)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .req_kind(req_tdata[2:0]),
      .req_index(req_tdata[4:3]), .req_value(req_tdata[20:5]), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_cmd(cmd), .rsp_last(rsp_tlast),
      .out_free(out_free), .sts(sts)
   );

   assign rsp_tdata = {3'd0, cmd.pattern, cmd.level, cmd.action, cmd.target};
endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for haptic_actuator_pattern_scheduler
// holds a scoreboard class that also predicts commands; depends on hap_pkg and the block's rtl
module tb_top;
   import hap_pkg::*;

   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [1:0] target;
      logic [2:0] action;
      logic [15:0] level;
      logic [15:0] pattern;
      logic last;
   } result_type;

   class cmd_scoreboard;
      result_type pending_cmds[$];
      int errors;

      // scheduler shadow
      logic [15:0] timeout_reg, counts_reg;
      logic [7:0] ontime_reg, types_reg;
      logic [31:0] ticks;
      logic [15:0] keepalive;
      logic link;
      logic [2:0] mode[4];
      logic changed[4];
      logic [15:0] level[4], setting[4];
      logic [2:0] rot_pos[4];

      function new();
         timeout_reg = KeepaliveReset;
         ontime_reg = OnTimeReset;
         types_reg = TypesReset;
         counts_reg = CountsReset;
         ticks = 0;
         keepalive = KeepaliveReset;
         link = 0;
         errors = 0;
         for (int a = 0; a < 4; a++) begin
            mode[a] = MODE_OFF;
            changed[a] = 0;
            level[a] = 0;
            setting[a] = 0;
            rot_pos[a] = 0;
         end
      endfunction

      function void write_csr(logic [1:0] idx, logic [15:0] v);
         case (idx)
            CSR_TIMEOUT: timeout_reg = v;
            CSR_ONTIME: ontime_reg = v[7:0];
            CSR_TYPES: types_reg = v[7:0];
            default: counts_reg = v;
         endcase
      endfunction

      function void push(logic [1:0] t, logic [2:0] act, logic [15:0] lv, logic [15:0] pat);
         result_type r;
         r.target = t;
         r.action = act;
         r.level = lv;
         r.pattern = pat;
         r.last = 0;
         pending_cmds.push_back(r);
      endfunction

      function void note_word(logic [2:0] kind, logic [1:0] idx, logic [15:0] val);
         int before_n;
         logic [1:0] ty;
         logic [31:0] period, rem;
         int cnt;
         before_n = pending_cmds.size();
         if (kind == KIND_PING) begin
            link = 1;
            keepalive = timeout_reg;
            return;
         end
         if (kind == KIND_MODE || kind == KIND_LEVEL || kind == KIND_PARAM) begin
            if (kind == KIND_MODE) begin
               if (val <= 16'(MODE_ELEC)) mode[idx] = val[2:0];
            end else if (kind == KIND_LEVEL) level[idx] = val;
            else setting[idx] = val;
            changed[idx] = 1;
            return;
         end
         if (kind != KIND_TICK) return;
         ticks++;
         if (link) begin
            keepalive--;
            if (keepalive == 0) begin
               link = 0;
               push(2'd0, ACT_DISC, 16'd0, 16'd0);
            end
         end
         for (int a = 0; a < 4; a++) begin
            ty = types_reg[2*a +: 2];
            case (mode[a])
               MODE_OFF: if (changed[a]) begin
                  changed[a] = 0;
                  push(2'(a), ACT_OFF, 16'd0, 16'd0);
               end
               MODE_TEMP: if (ty == TYPE_TEMP && changed[a]) begin
                  changed[a] = 0;
                  push(2'(a), ACT_TEMP, level[a], 16'd0);
               end
               MODE_SERVO: if (ty == TYPE_PRES && changed[a]) begin
                  changed[a] = 0;
                  push(2'(a), ACT_SERVO, level[a], 16'd0);
               end
               MODE_VIB: if (ty == TYPE_VIB && changed[a]) begin
                  changed[a] = 0;
                  push(2'(a), ACT_VIB, level[a], setting[a]);
               end
               MODE_BEAT: if (ty == TYPE_VIB) begin
                  if (changed[a]) begin
                     changed[a] = 0;
                     push(2'(a), ACT_VIB, 16'd0, 16'd0);
                  end
                  period = 32'(ontime_reg) + 32'(setting[a]);
                  if (period != 0) begin
                     rem = ticks % period;
                     if (rem == 0) push(2'(a), ACT_VIB, level[a], BeatPattern);
                     else if (rem == 32'(ontime_reg)) push(2'(a), ACT_VIB, 16'd0, 16'd0);
                  end
               end
               MODE_ROT: if (ty == TYPE_VIB) begin
                  if (changed[a]) begin
                     changed[a] = 0;
                     push(2'(a), ACT_VIB, 16'd0, 16'd0);
                  end
                  if (setting[a] != 0 && ticks % 32'(setting[a]) == 0) begin
                     cnt = int'(counts_reg[4*a +: 4]);
                     if (cnt == 0) cnt = 1;
                     if (cnt > 8) cnt = 8;
                     rot_pos[a] = 3'((int'(rot_pos[a]) + 1) % cnt);
                     push(2'(a), ACT_VIB, level[a], 16'(1) << rot_pos[a]);
                  end
               end
               MODE_ELEC: if (ty == TYPE_ELEC && changed[a]) begin
                  changed[a] = 0;
                  push(2'(a), ACT_ELEC, level[a], 16'd0);
               end
               default: ;
            endcase
         end
         if (pending_cmds.size() > before_n)
            pending_cmds[pending_cmds.size()-1].last = 1;
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (pending_cmds.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         want = pending_cmds.pop_front();
         if (got.target !== want.target)
            report($sformatf("target %0d want %0d", got.target, want.target));
         if (got.action !== want.action)
            report($sformatf("action %0d want %0d", got.action, want.action));
         if (got.level !== want.level)
            report($sformatf("level %h want %h", got.level, want.level));
         if (got.pattern !== want.pattern)
            report($sformatf("pattern %h want %h", got.pattern, want.pattern));
         if (got.last !== want.last)
            report($sformatf("last %b want %b", got.last, want.last));
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [23:0] req_tdata = 0;
   logic rsp_tvalid, rsp_tready = 0, rsp_tlast;
   logic [39:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [15:0] csr_wdata = 0;

   cmd_scoreboard sb = new();
   bit calm = 0;
   int idle_cycles = 0;
   bit done = 0;

   haptic_actuator_pattern_scheduler i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else rsp_tready <= calm || $urandom_range(99) >= 9;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word({rsp_tdata[1:0], rsp_tdata[4:2], rsp_tdata[20:5], rsp_tdata[36:21],
                        rsp_tlast});
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_we)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000 && !done) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic send_word(logic [2:0] kind, logic [1:0] idx, logic [15:0] val);
      while (!calm && $urandom_range(99) < 9) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b0, val, idx, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(kind, idx, val);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_cmds.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.write_csr(idx, v);
   endtask

   task automatic rand_word();
      int r;
      logic [15:0] v;
      r = $urandom_range(99);
      v = $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom);
      if (r < 55) send_word(KIND_TICK, 2'd0, 16'($urandom));
      else if (r < 62) send_word(KIND_PING, 2'($urandom), 16'($urandom));
      else if (r < 74) send_word(KIND_MODE, 2'($urandom), 16'($urandom_range(7)));
      else if (r < 82) send_word(KIND_LEVEL, 2'($urandom), 16'($urandom));
      else if (r < 96) send_word(KIND_PARAM, 2'($urandom), v);
      else send_word(3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)), 2'($urandom),
                     16'($urandom));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: every mode, extremes, ignored kinds, short keepalive
      write_reg(CSR_TIMEOUT, 16'd3);
      send_word(KIND_PING, 2'd0, 16'd0);
      send_word(KIND_MODE, 2'd0, 16'(MODE_BEAT));
      send_word(KIND_LEVEL, 2'd0, 16'hFFFF);
      send_word(KIND_PARAM, 2'd1, 16'd2);
      send_word(KIND_MODE, 2'd1, 16'(MODE_ROT));
      send_word(KIND_LEVEL, 2'd1, 16'h8001);
      send_word(KIND_MODE, 2'd2, 16'(MODE_VIB));
      send_word(KIND_PARAM, 2'd2, 16'hFFFF);
      send_word(KIND_MODE, 2'd3, 16'd7);
      send_word(KIND_UNUSED_LO, 2'd3, 16'hFFFF);
      send_word(KIND_UNUSED_HI, 2'd0, 16'd0);
      repeat (5) send_word(KIND_TICK, 2'd0, 16'd0);
      drain();
      write_reg(CSR_TYPES, 16'b11_10_01_00);
      write_reg(CSR_COUNTS, 16'hF010);
      write_reg(CSR_ONTIME, 16'd255);
      send_word(KIND_MODE, 2'd1, 16'(MODE_TEMP));
      send_word(KIND_MODE, 2'd2, 16'(MODE_SERVO));
      send_word(KIND_MODE, 2'd3, 16'(MODE_ELEC));
      send_word(KIND_PARAM, 2'd0, 16'd0);
      send_word(KIND_MODE, 2'd0, 16'(MODE_ROT));
      repeat (3) send_word(KIND_TICK, 2'd0, 16'd0);
      drain();
      // random phases with different settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_TIMEOUT, ph == 0 ? 16'd1 : ph == 1 ? 16'hFFFF : 16'($urandom_range(40, 1)));
         write_reg(CSR_ONTIME, ph == 2 ? 16'd1 : ph == 3 ? 16'd0 : 16'($urandom_range(12)));
         write_reg(CSR_TYPES, ph < 2 ? 16'h00 : 16'($urandom_range(255)));
         write_reg(CSR_COUNTS, ph == 4 ? 16'hFFFF : ph == 5 ? 16'h0000 : 16'($urandom));
         calm = (ph == 2);
         for (int k = 0; k < 55; k++) rand_word();
         calm = 0;
         drain();
      end
      done = 1;
      if (sb.errors == 0 && sb.pending_cmds.size() == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end
endmodule

@@ haptic_actuator_pattern_scheduler.f @@
src/hap_pkg.sv
src/hap_rem.sv
src/hap_ctrl.sv
src/hap_dp.sv
src/haptic_actuator_pattern_scheduler.sv
tb/tb_top.sv
